/* rtl/framebuffer_line_rect_draw_engine_top_assert.svh */
// Assertion macros for the framebuffer draw engine top level.
`ifndef FRAMEBUFFER_LINE_RECT_DRAW_ENGINE_TOP_ASSERT_SVH
`define FRAMEBUFFER_LINE_RECT_DRAW_ENGINE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FBDRAW_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fbdraw: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define FBDRAW_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fbdraw: next-cycle check failed");

`endif

/* rtl/fbdraw_pkg.sv */
// Shared types and constants of the framebuffer draw engine.
package fbdraw_pkg;

    localparam int DEF_STORE_WIDTH  = 256;
    localparam int DEF_STORE_HEIGHT = 256;

    localparam int FUNC_W   = 2;
    localparam int COORD_W  = 8;
    localparam int COLOUR_W = 32;

    // Line arithmetic: Q8.16 positions, one spare integer bit and a sign bit
    localparam int FRAC_W  = 16;
    localparam int PIX_W   = COORD_W + 1;
    localparam int POS_W   = PIX_W + FRAC_W + 1;
    localparam int INC_W   = FRAC_W + 2;
    localparam int HALF_Q  = 1 << (FRAC_W - 1);

    // Increment divider: ({mag, 16'b0} + side/2) / side
    localparam int DIV_NUM_W = COORD_W + FRAC_W;
    localparam int DIV_DEN_W = COORD_W;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_RECT  = 2'd1,
        FUNC_LINE  = 2'd2,
        FUNC_READ  = 2'd3
    } func_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic clr_step;
        logic rect_step;
        logic div_start;
        logic div_sel_y;
        logic inc_x_load;
        logic inc_y_load;
        logic line_step;
        logic rd_issue;
        logic rsp_load;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic rect_bad;
        logic rect_last;
        logic side_zero;
        logic div_busy;
        logic div_done;
        logic line_last;
    } dp_stat_t;

endpackage

/* rtl/fbdraw_cmd_if.sv */
// Command channel: valid/ready handshake and the draw command payload.
interface fbdraw_cmd_if import fbdraw_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [COORD_W-1:0]  x_start;
    logic [COORD_W-1:0]  y_start;
    logic [COORD_W-1:0]  x_end;
    logic [COORD_W-1:0]  y_end;
    logic [COORD_W-1:0]  rect_width;
    logic [COORD_W-1:0]  rect_height;
    logic [COLOUR_W-1:0] colour;

    modport source (
        output valid, func, x_start, y_start, x_end, y_end,
               rect_width, rect_height, colour,
        input  ready
    );

    modport sink (
        input  valid, func, x_start, y_start, x_end, y_end,
               rect_width, rect_height, colour,
        output ready
    );
endinterface

/* rtl/fbdraw_rsp_if.sv */
// Response channel: valid/ready handshake and the result payload.
interface fbdraw_rsp_if import fbdraw_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [COLOUR_W-1:0] read_colour;
    logic                rect_rejected;

    modport source (
        output valid, read_colour, rect_rejected,
        input  ready
    );

    modport sink (
        input  valid, read_colour, rect_rejected,
        output ready
    );
endinterface

/* rtl/fbdraw_ram.sv */
// Generic single-port RAM with registered read data.
module fbdraw_ram import fbdraw_pkg::*; #(
    parameter int WIDTH = COLOUR_W,
    parameter int DEPTH = DEF_STORE_WIDTH * DEF_STORE_HEIGHT
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on we; read registered, returning the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[addr] <= wdata;
        end
        rdata_reg <= mem_array[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/fbdraw_div.sv */
// Bit-serial restoring divider for the line increments.
module fbdraw_div import fbdraw_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 busy,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);
    localparam int REM_W = DIV_DEN_W + 1;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;

    logic [REM_W-1:0]     shifted;
    logic [REM_W:0]       diff;
    logic                 ge;

    // One quotient bit per cycle
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIV_NUM_W-1]};
        diff      = {1'b0, shifted} - {2'b00, den_reg};
        ge        = !diff[REM_W];
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_NUM_W);
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quo_reg;

endmodule

/* rtl/fbdraw_datapath.sv */
// Datapath: command registers, walkers, line DDA, pixel store and result registers.
module fbdraw_datapath import fbdraw_pkg::*; #(
    parameter int STORE_WIDTH  = DEF_STORE_WIDTH,
    parameter int STORE_HEIGHT = DEF_STORE_HEIGHT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             ctl,
    output dp_stat_t            stat,
    input  logic [FUNC_W-1:0]   func,
    input  logic [COORD_W-1:0]  x_start,
    input  logic [COORD_W-1:0]  y_start,
    input  logic [COORD_W-1:0]  x_end,
    input  logic [COORD_W-1:0]  y_end,
    input  logic [COORD_W-1:0]  rect_width,
    input  logic [COORD_W-1:0]  rect_height,
    input  logic [COLOUR_W-1:0] colour,
    output logic [COLOUR_W-1:0] read_colour,
    output logic                rect_rejected
);

    localparam int DEPTH  = STORE_WIDTH * STORE_HEIGHT;
    localparam int AW     = $clog2(DEPTH);
    localparam int MAXDIM = (STORE_WIDTH > STORE_HEIGHT) ? STORE_WIDTH : STORE_HEIGHT;
    localparam int DIM_W  = $clog2(MAXDIM) + 1;
    localparam int CMP_W  = (DIM_W > PIX_W + 1) ? DIM_W : PIX_W + 1;

    // Latched command
    logic [FUNC_W-1:0]   func_reg;
    logic [COORD_W-1:0]  x0_reg, y0_reg, x1_reg, y1_reg, w_reg, h_reg;
    logic [COLOUR_W-1:0] colour_reg;

    // Walkers
    logic [AW-1:0]       clr_cnt_reg;
    logic [PIX_W-1:0]    cur_x_reg, cur_y_reg;
    logic [COORD_W-1:0]  step_cnt_reg;
    logic signed [INC_W-1:0] inc_x_reg, inc_y_reg;
    logic signed [POS_W-1:0] pos_x_reg, pos_y_reg;

    // Store port stage
    logic                wr_en_reg, wr_en_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic [COLOUR_W-1:0] wdata_reg, wdata_next;
    logic [COLOUR_W-1:0] rdata;

    // Result registers
    logic [COLOUR_W-1:0] read_colour_reg;
    logic                rect_rejected_reg;

    logic signed [COORD_W:0] dx, dy;
    logic [COORD_W-1:0]  ax, ay, side, mag;
    logic [PIX_W-1:0]    rect_right, rect_bottom;
    logic                rect_bad, rd_in;
    logic [DIV_NUM_W-1:0] div_num, div_quot;
    logic                div_busy, div_done;
    logic signed [INC_W-1:0] inc_mag, inc_new;
    logic                inc_neg;
    logic signed [POS_W-1:0] rx, ry;
    logic [PIX_W-1:0]    lx, ly;
    logic                line_in;

    function automatic logic [AW-1:0] xy_addr(input logic [PIX_W-1:0] px,
                                              input logic [PIX_W-1:0] py);
        return AW'(py) * AW'(STORE_WIDTH) + AW'(px);
    endfunction

    // Line geometry, divider numerator, rectangle and read bounds
    always_comb
    begin
        dx   = $signed({1'b0, x1_reg}) - $signed({1'b0, x0_reg});
        dy   = $signed({1'b0, y1_reg}) - $signed({1'b0, y0_reg});
        ax   = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
        ay   = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
        side = (ax >= ay) ? ax : ay;
        mag  = ctl.div_sel_y ? ay : ax;
        div_num = {mag, FRAC_W'(0)} + DIV_NUM_W'(side[COORD_W-1:1]);

        rect_right  = {1'b0, x0_reg} + {1'b0, w_reg};
        rect_bottom = {1'b0, y0_reg} + {1'b0, h_reg};
        rect_bad    = (CMP_W'(rect_right) >= CMP_W'(STORE_WIDTH)) ||
                      (CMP_W'(rect_bottom) >= CMP_W'(STORE_HEIGHT));
        rd_in       = (CMP_W'(x0_reg) < CMP_W'(STORE_WIDTH)) &&
                      (CMP_W'(y0_reg) < CMP_W'(STORE_HEIGHT));
    end

    // Signed increment from the unsigned quotient
    always_comb
    begin
        inc_neg = ctl.inc_y_load ? dy[COORD_W] : dx[COORD_W];
        inc_mag = $signed({1'b0, div_quot[INC_W-2:0]});
        inc_new = inc_neg ? -inc_mag : inc_mag;
    end

    // Round Q8.16 positions to pixel coordinates, clip to the store
    always_comb
    begin
        rx = pos_x_reg + POS_W'(HALF_Q);
        ry = pos_y_reg + POS_W'(HALF_Q);
        lx = rx[FRAC_W +: PIX_W];
        ly = ry[FRAC_W +: PIX_W];
        line_in = !rx[POS_W-1] && !ry[POS_W-1] &&
                  (CMP_W'(lx) < CMP_W'(STORE_WIDTH)) &&
                  (CMP_W'(ly) < CMP_W'(STORE_HEIGHT));
    end

    fbdraw_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.div_start),
        .num   (div_num),
        .den   (side),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Command latch and walker updates
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            func_reg     <= func;
            x0_reg       <= x_start;
            y0_reg       <= y_start;
            x1_reg       <= x_end;
            y1_reg       <= y_end;
            w_reg        <= rect_width;
            h_reg        <= rect_height;
            colour_reg   <= colour;
            clr_cnt_reg  <= '0;
            cur_x_reg    <= {1'b0, x_start};
            cur_y_reg    <= {1'b0, y_start};
            step_cnt_reg <= '0;
            pos_x_reg    <= $signed(POS_W'({x_start, FRAC_W'(0)}));
            pos_y_reg    <= $signed(POS_W'({y_start, FRAC_W'(0)}));
        end
        if (ctl.clr_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
        if (ctl.rect_step)
        begin
            if (cur_x_reg == rect_right)
            begin
                cur_x_reg <= {1'b0, x0_reg};
                cur_y_reg <= cur_y_reg + 1'b1;
            end
            else
            begin
                cur_x_reg <= cur_x_reg + 1'b1;
            end
        end
        if (ctl.inc_x_load)
        begin
            inc_x_reg <= inc_new;
        end
        if (ctl.inc_y_load)
        begin
            inc_y_reg <= inc_new;
        end
        if (ctl.line_step)
        begin
            step_cnt_reg <= step_cnt_reg + 1'b1;
            pos_x_reg    <= pos_x_reg + {{(POS_W-INC_W){inc_x_reg[INC_W-1]}}, inc_x_reg};
            pos_y_reg    <= pos_y_reg + {{(POS_W-INC_W){inc_y_reg[INC_W-1]}}, inc_y_reg};
        end
        if (ctl.rsp_load)
        begin
            read_colour_reg   <= ((func_reg == FUNC_READ) && rd_in) ? rdata : '0;
            rect_rejected_reg <= (func_reg == FUNC_RECT) && rect_bad;
        end
    end

    // Store port: one access per cycle
    always_comb
    begin
        wr_en_next = 1'b0;
        addr_next  = addr_reg;
        wdata_next = wdata_reg;
        if (ctl.clr_step)
        begin
            wr_en_next = 1'b1;
            addr_next  = clr_cnt_reg;
            wdata_next = colour_reg;
        end
        else if (ctl.rect_step)
        begin
            wr_en_next = 1'b1;
            addr_next  = xy_addr(cur_x_reg, cur_y_reg);
            wdata_next = colour_reg;
        end
        else if (ctl.line_step)
        begin
            wr_en_next = line_in;
            addr_next  = xy_addr(lx, ly);
            wdata_next = colour_reg;
        end
        else if (ctl.rd_issue)
        begin
            addr_next = xy_addr({1'b0, x0_reg}, {1'b0, y0_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_en_reg <= 1'b0;
        end
        else
        begin
            wr_en_reg <= wr_en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        wdata_reg <= wdata_next;
    end

    fbdraw_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (wr_en_reg),
        .addr  (addr_reg),
        .wdata (wdata_reg),
        .rdata (rdata)
    );

    // Status to controller
    always_comb
    begin
        stat.clr_last  = (clr_cnt_reg == AW'(DEPTH - 1));
        stat.rect_bad  = rect_bad;
        stat.rect_last = (cur_x_reg == rect_right) && (cur_y_reg == rect_bottom);
        stat.side_zero = (side == '0);
        stat.div_busy  = div_busy;
        stat.div_done  = div_done;
        stat.line_last = (step_cnt_reg == side - 1'b1);
    end

    assign read_colour   = read_colour_reg;
    assign rect_rejected = rect_rejected_reg;

endmodule

/* rtl/fbdraw_ctrl.sv */
// Controller state machine: sequences clear, rectangle, line and read commands.
module fbdraw_ctrl import fbdraw_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  logic [FUNC_W-1:0] func,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output dp_cmd_t           ctl,
    input  dp_stat_t          stat
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RECT,
        ST_DIVX,
        ST_DIVX_WAIT,
        ST_DIVY,
        ST_DIVY_WAIT,
        ST_LINE,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   rsp_free;

    always_comb
    begin
        state_next     = state_reg;
        ctl            = '0;
        rsp_free       = !rsp_valid_reg || rsp_ready;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.load = 1'b1;
                    case (func_t'(func))
                        FUNC_CLEAR: state_next = ST_CLEAR;
                        FUNC_RECT:  state_next = ST_RECT;
                        FUNC_LINE:  state_next = ST_DIVX;
                        FUNC_READ:  state_next = ST_RD_ISSUE;
                        default:    state_next = ST_RD_ISSUE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_RECT:
            begin
                if (stat.rect_bad)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    ctl.rect_step = 1'b1;
                    if (stat.rect_last)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_DIVX:
            begin
                if (stat.side_zero)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    ctl.div_start = 1'b1;
                    state_next    = ST_DIVX_WAIT;
                end
            end
            ST_DIVX_WAIT:
            begin
                if (stat.div_done)
                begin
                    ctl.inc_x_load = 1'b1;
                    state_next     = ST_DIVY;
                end
            end
            ST_DIVY:
            begin
                ctl.div_start = 1'b1;
                ctl.div_sel_y = 1'b1;
                state_next    = ST_DIVY_WAIT;
            end
            ST_DIVY_WAIT:
            begin
                if (stat.div_done)
                begin
                    ctl.inc_y_load = 1'b1;
                    state_next     = ST_LINE;
                end
            end
            ST_LINE:
            begin
                ctl.line_step = 1'b1;
                if (stat.line_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_RD_ISSUE:
            begin
                ctl.rd_issue = 1'b1;
                state_next   = ST_RD_WAIT;
            end
            ST_RD_WAIT:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // Wait for the result register to free up
                if (rsp_free)
                begin
                    ctl.rsp_load   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign cmd_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

/* rtl/framebuffer_line_rect_draw_engine_top.sv */
// Top level of the framebuffer draw engine: controller, datapath and checks.
// Usage:
//   cmd channel (valid/ready): one beat is one draw command (func, coordinates,
//   rectangle extent, colour). rsp channel (valid/ready): one beat per command,
//   carrying read_colour (read results, else zero) and rect_rejected.
//   Commands run one at a time; cmd.ready is high only while the engine is idle.
//   Steps from command beat to response, with one store access per cycle:
//     clear      writes every pixel of the store
//     rectangle  writes each pixel of the rectangle, or none when rejected
//     line       two bit-serial divisions, then side pixels at one per cycle;
//                a zero-length line draws nothing
//     read       one registered store read
//   A new command beat can be taken in the cycle the response goes valid.
//   The store port allows one write or read per cycle.
//   Reset clears the control state only; store contents are undefined until
//   written. A finished result waits in an output register; if the receiver
//   stalls, the engine still takes the next command and holds its result
//   until the previous beat has been taken.
`include "framebuffer_line_rect_draw_engine_top_assert.svh"

module framebuffer_line_rect_draw_engine_top import fbdraw_pkg::*; #(
    parameter int STORE_WIDTH  = DEF_STORE_WIDTH,
    parameter int STORE_HEIGHT = DEF_STORE_HEIGHT
) (
    input  logic          clk,
    input  logic          rst_n,
    fbdraw_cmd_if.sink    cmd,
    fbdraw_rsp_if.source  rsp
);

    dp_cmd_t  dp_ctl;
    dp_stat_t dp_stat;

    fbdraw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .func      (cmd.func),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .ctl       (dp_ctl),
        .stat      (dp_stat)
    );

    fbdraw_datapath #(
        .STORE_WIDTH  (STORE_WIDTH),
        .STORE_HEIGHT (STORE_HEIGHT)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (dp_ctl),
        .stat          (dp_stat),
        .func          (cmd.func),
        .x_start       (cmd.x_start),
        .y_start       (cmd.y_start),
        .x_end         (cmd.x_end),
        .y_end         (cmd.y_end),
        .rect_width    (cmd.rect_width),
        .rect_height   (cmd.rect_height),
        .colour        (cmd.colour),
        .read_colour   (rsp.read_colour),
        .rect_rejected (rsp.rect_rejected)
    );

    // Engine is busy right after taking a command
    `FBDRAW_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, cmd.valid && cmd.ready, !cmd.ready)
    // Divider is never restarted mid-division
    `FBDRAW_ASSERT_SAME(a_div_start_idle, clk, rst_n, dp_ctl.div_start, !dp_stat.div_busy)
    // A rejected rectangle never carries read data
    `FBDRAW_ASSERT_SAME(a_reject_no_data, clk, rst_n, rsp.valid && rsp.rect_rejected, rsp.read_colour == '0)

endmodule

/* tb/sv/tb_framebuffer_line_rect_draw_engine_top.sv */
// Testbench of the framebuffer draw engine: draw commands checked against a shadow store.
`timescale 1ns / 100ps

module tb_framebuffer_line_rect_draw_engine_top;
    import fbdraw_pkg::*;

    localparam int FB_W        = DEF_STORE_WIDTH;
    localparam int FB_H        = DEF_STORE_HEIGHT;
    localparam int RANDOM_CMDS = 1080;
    localparam int IDLE_PCT    = 30;
    localparam int STALL_LIMIT = 400000;
    localparam int TAIL_CYCLES = 64;
    localparam int MAX_PRINTS  = 200;

    typedef struct packed {
        func_t               func;
        logic [COORD_W-1:0]  x_start;
        logic [COORD_W-1:0]  y_start;
        logic [COORD_W-1:0]  x_end;
        logic [COORD_W-1:0]  y_end;
        logic [COORD_W-1:0]  rect_width;
        logic [COORD_W-1:0]  rect_height;
        logic [COLOUR_W-1:0] colour;
        logic                drain_first;
    } draw_cmd_t;

    typedef struct packed {
        logic [COLOUR_W-1:0] read_colour;
        logic                rect_rejected;
    } draw_outcome_t;

    logic clk;
    logic rst_n;

    fbdraw_cmd_if cmd_ch ();
    fbdraw_rsp_if rsp_ch ();

    framebuffer_line_rect_draw_engine_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the pixel store, commands waiting to go out, outcomes owed
    logic [COLOUR_W-1:0] shadow_fb [0:FB_W*FB_H-1];
    draw_cmd_t           cmd_backlog [$];
    draw_outcome_t       cmd_outcomes [$];
    draw_cmd_t           cmd_live;

    int   cmds_total    = 0;
    int   cmds_accepted = 0;
    int   rsps_accepted = 0;
    int   mismatches    = 0;
    int   quiet_cycles  = 0;
    logic steady;

    // No idling on either side for a stretch in the middle of the run
    assign steady = (cmds_accepted >= 500) && (cmds_accepted < 650);

    // Clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatches < MAX_PRINTS)
            $display("%0t beat %0d: %s got %h want %h", $time, rsps_accepted, what, got, want);
        mismatches++;
    endtask

    task automatic push_cmd(func_t f, int xs, int ys, int xe, int ye, int w, int h,
                            logic [COLOUR_W-1:0] col, logic drain);
        draw_cmd_t c;
        c.func        = f;
        c.x_start     = xs[7:0];
        c.y_start     = ys[7:0];
        c.x_end       = xe[7:0];
        c.y_end       = ye[7:0];
        c.rect_width  = w[7:0];
        c.rect_height = h[7:0];
        c.colour      = col;
        c.drain_first = drain;
        cmd_backlog.push_back(c);
    endtask

    // Q1.16 increment, rounded to nearest with ties away from zero
    function automatic int q16_inc(int delta, int side);
        int mag;
        int q;
        mag = (delta < 0) ? -delta : delta;
        q   = ((mag << FRAC_W) + side / 2) / side;
        return (delta < 0) ? -q : q;
    endfunction

    // Round a Q8.16 position to a pixel index; negative maps off the store
    function automatic int q16_pixel(int pos);
        int r;
        r = pos + HALF_Q;
        return (r < 0) ? -1 : (r >>> FRAC_W);
    endfunction

    function automatic void plot(int px, int py, logic [COLOUR_W-1:0] col);
        if (px >= 0 && py >= 0 && px < FB_W && py < FB_H)
            shadow_fb[py * FB_W + px] = col;
    endfunction

    // Apply one command to the shadow store and return the response it owes
    function automatic draw_outcome_t run_draw_cmd(draw_cmd_t c);
        draw_outcome_t res;
        int dx, dy, ax, ay, side, xi, yi, px, py;
        res = '0;
        case (c.func)
            FUNC_CLEAR:
            begin
                for (int i = 0; i < FB_W * FB_H; i++)
                    shadow_fb[i] = c.colour;
            end
            FUNC_RECT:
            begin
                if (int'(c.x_start) + int'(c.rect_width) >= FB_W ||
                    int'(c.y_start) + int'(c.rect_height) >= FB_H)
                    res.rect_rejected = 1'b1;
                else
                begin
                    for (int yy = c.y_start; yy <= int'(c.y_start) + int'(c.rect_height); yy++)
                        for (int xx = c.x_start; xx <= int'(c.x_start) + int'(c.rect_width); xx++)
                            shadow_fb[yy * FB_W + xx] = c.colour;
                end
            end
            FUNC_LINE:
            begin
                dx   = int'(c.x_end) - int'(c.x_start);
                dy   = int'(c.y_end) - int'(c.y_start);
                ax   = (dx < 0) ? -dx : dx;
                ay   = (dy < 0) ? -dy : dy;
                side = (ax >= ay) ? ax : ay;
                if (side != 0)
                begin
                    xi = q16_inc(dx, side);
                    yi = q16_inc(dy, side);
                    px = int'(c.x_start) << FRAC_W;
                    py = int'(c.y_start) << FRAC_W;
                    // final endpoint is left out
                    for (int i = 0; i < side; i++)
                    begin
                        plot(q16_pixel(px), q16_pixel(py), c.colour);
                        px += xi;
                        py += yi;
                    end
                end
            end
            default:
            begin
                res.read_colour = shadow_fb[int'(c.y_start) * FB_W + int'(c.x_start)];
            end
        endcase
        return res;
    endfunction

    // Command driver: one beat at a time from the backlog
    always @(posedge clk or negedge rst_n)
    begin : drive_cmds
        int owed;
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
        end
        else
        begin
            owed = cmds_accepted - rsps_accepted;
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                cmd_outcomes.push_back(run_draw_cmd(cmd_live));
                cmds_accepted <= cmds_accepted + 1;
                owed++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
                owed--;
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (cmd_backlog.size() != 0 &&
                    (steady || $urandom_range(0, 99) >= IDLE_PCT) &&
                    !(cmd_backlog[0].drain_first && owed != 0))
                begin
                    cmd_live            = cmd_backlog.pop_front();
                    cmd_ch.func        <= cmd_live.func;
                    cmd_ch.x_start     <= cmd_live.x_start;
                    cmd_ch.y_start     <= cmd_live.y_start;
                    cmd_ch.x_end       <= cmd_live.x_end;
                    cmd_ch.y_end       <= cmd_live.y_end;
                    cmd_ch.rect_width  <= cmd_live.rect_width;
                    cmd_ch.rect_height <= cmd_live.rect_height;
                    cmd_ch.colour      <= cmd_live.colour;
                    cmd_ch.valid       <= 1'b1;
                end
                else
                begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: compare each beat with the oldest owed outcome
    always @(posedge clk or negedge rst_n)
    begin : check_rsps
        draw_outcome_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                rsps_accepted <= rsps_accepted + 1;
                if (cmd_outcomes.size() == 0)
                    note_mismatch("response with nothing owed", rsp_ch.read_colour, '0);
                else
                begin
                    want = cmd_outcomes.pop_front();
                    if (rsp_ch.read_colour !== want.read_colour)
                        note_mismatch("read_colour", rsp_ch.read_colour, want.read_colour);
                    if (rsp_ch.rect_rejected !== want.rect_rejected)
                        note_mismatch("rect_rejected", {31'b0, rsp_ch.rect_rejected},
                                      {31'b0, want.rect_rejected});
                end
            end
            rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: too long without any beat on either channel
    always @(posedge clk)
    begin
        if (rst_n && !((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)))
            quiet_cycles <= quiet_cycles + 1;
        else
            quiet_cycles <= 0;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Stimulus and end of run
    initial
    begin
        logic [COORD_W-1:0] hot_x [$];
        logic [COORD_W-1:0] hot_y [$];
        logic [COLOUR_W-1:0] col;
        logic drain;
        int xs, ys, xe, ye, w, h, roll, kind, pick;

        rst_n              = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.func        = FUNC_CLEAR;
        cmd_ch.x_start     = '0;
        cmd_ch.y_start     = '0;
        cmd_ch.x_end       = '0;
        cmd_ch.y_end       = '0;
        cmd_ch.rect_width  = '0;
        cmd_ch.rect_height = '0;
        cmd_ch.colour      = '0;
        rsp_ch.ready       = 1'b0;

        // Directed: clears, reads, full and edge rectangles, rejections, line shapes
        push_cmd(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 1'b0);
        push_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 32'h0, 1'b0);
        push_cmd(FUNC_READ, 255, 255, 0, 0, 0, 0, 32'h0, 1'b0);
        push_cmd(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 32'h0000_0000, 1'b1);
        push_cmd(FUNC_READ, 128, 77, 0, 0, 0, 0, 32'h0, 1'b0);
        push_cmd(FUNC_RECT, 0, 0, 0, 0, 255, 255, 32'hA5A5_5A5A, 1'b0);
        push_cmd(FUNC_READ, 255, 255, 0, 0, 0, 0, 32'h0, 1'b1);
        // right edge reached exactly: refused
        push_cmd(FUNC_RECT, 1, 0, 0, 0, 255, 0, 32'h1234_5678, 1'b0);
        // bottom edge reached exactly: refused
        push_cmd(FUNC_RECT, 0, 200, 0, 0, 0, 56, 32'h1234_5678, 1'b0);
        // single pixel in the far corner
        push_cmd(FUNC_RECT, 255, 255, 0, 0, 0, 0, 32'h8000_0001, 1'b0);
        push_cmd(FUNC_READ, 255, 255, 0, 0, 0, 0, 32'h0, 1'b0);
        push_cmd(FUNC_RECT, 1, 10, 0, 0, 254, 0, 32'h7FFF_FFFE, 1'b0);
        push_cmd(FUNC_READ, 255, 10, 0, 0, 0, 0, 32'h0, 1'b0);
        push_cmd(FUNC_READ, 0, 10, 0, 0, 0, 0, 32'h0, 1'b0);
        // zero-length line draws nothing
        push_cmd(FUNC_LINE, 40, 40, 40, 40, 0, 0, 32'hDEAD_BEEF, 1'b0);
        push_cmd(FUNC_READ, 40, 40, 0, 0, 0, 0, 32'h0, 1'b0);
        push_cmd(FUNC_LINE, 0, 0, 255, 0, 0, 0, 32'h0F0F_F0F0, 1'b0);
        push_cmd(FUNC_READ, 254, 0, 0, 0, 0, 0, 32'h0, 1'b0);
        push_cmd(FUNC_READ, 255, 0, 0, 0, 0, 0, 32'h0, 1'b0);
        push_cmd(FUNC_LINE, 255, 255, 255, 0, 0, 0, 32'h5555_AAAA, 1'b0);
        push_cmd(FUNC_READ, 255, 1, 0, 0, 0, 0, 32'h0, 1'b0);
        push_cmd(FUNC_LINE, 0, 255, 255, 0, 0, 0, 32'hC3C3_3C3C, 1'b0);
        push_cmd(FUNC_LINE, 10, 10, 13, 200, 0, 0, 32'h0000_FFFF, 1'b0);
        push_cmd(FUNC_READ, 11, 100, 0, 0, 0, 0, 32'h0, 1'b0);

        // Random: lines, rectangles (mostly small), reads (often of drawn pixels) and two clears
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            col   = $urandom;
            drain = ($urandom_range(0, 99) == 0);
            xs    = $urandom_range(0, 255);
            ys    = $urandom_range(0, 255);
            xe    = $urandom_range(0, 255);
            ye    = $urandom_range(0, 255);
            w     = $urandom_range(0, 255);
            h     = $urandom_range(0, 255);
            roll  = $urandom_range(0, 999);
            if (n == RANDOM_CMDS / 3 || n == 2 * RANDOM_CMDS / 3)
            begin
                push_cmd(FUNC_CLEAR, xs, ys, xe, ye, w, h, col, drain);
            end
            else if (roll < 360)
            begin
                kind = $urandom_range(0, 9);
                if (kind < 3)
                begin
                    // short line near the start
                    xe = xs + $urandom_range(0, 16) - 8;
                    ye = ys + $urandom_range(0, 16) - 8;
                    xe = (xe < 0) ? 0 : ((xe > 255) ? 255 : xe);
                    ye = (ye < 0) ? 0 : ((ye > 255) ? 255 : ye);
                end
                else if (kind == 3)
                    xe = xs;
                else if (kind == 4)
                    ye = ys;
                else if (kind == 5)
                begin
                    xe = xs;
                    ye = ys;
                end
                push_cmd(FUNC_LINE, xs, ys, xe, ye, w, h, col, drain);
                hot_x.push_back(xs[7:0]);
                hot_y.push_back(ys[7:0]);
            end
            else if (roll < 680)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 70)
                begin
                    w = $urandom_range(0, 15);
                    h = $urandom_range(0, 15);
                end
                else if (kind < 85)
                begin
                    // reach the last column and row, or one past them
                    w  = $urandom_range(1, 16);
                    h  = $urandom_range(1, 16);
                    xs = FB_W - w - $urandom_range(0, 1);
                    ys = FB_H - h - $urandom_range(0, 1);
                end
                else if (kind < 99)
                begin
                    // wide and off the right edge
                    w  = $urandom_range(128, 255);
                    xs = $urandom_range(FB_W - w, 255);
                end
                else
                begin
                    // large rectangle that fits
                    xs = $urandom_range(0, 255 - w);
                    ys = $urandom_range(0, 255 - h);
                end
                push_cmd(FUNC_RECT, xs, ys, xe, ye, w, h, col, drain);
                hot_x.push_back(xs[7:0]);
                hot_y.push_back(ys[7:0]);
                if (xs + w < FB_W && ys + h < FB_H)
                begin
                    hot_x.push_back(8'(xs + w));
                    hot_y.push_back(8'(ys + h));
                end
            end
            else
            begin
                if (hot_x.size() != 0 && $urandom_range(0, 1) == 1)
                begin
                    pick = $urandom_range(0, hot_x.size() - 1);
                    xs   = hot_x[pick];
                    ys   = hot_y[pick];
                end
                push_cmd(FUNC_READ, xs, ys, xe, ye, w, h, col, drain);
            end
            while (hot_x.size() > 32)
            begin
                hot_x.pop_front();
                hot_y.pop_front();
            end
        end
        cmds_total = cmd_backlog.size();

        // Reset
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every command beat, then every response beat
        while (cmds_accepted != cmds_total)
            @(posedge clk);
        while (rsps_accepted < cmds_total)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (cmd_outcomes.size() != 0)
            note_mismatch("responses never seen", cmd_outcomes.size(), '0);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
